// ----- src/trq_pkg.sv -----
// ============================================================================
// trq_pkg
// Shared types and constants for the task ready queue and timer scheduler.
// ============================================================================
`default_nettype none

package trq_pkg;

    localparam int TASK_ID_W  = 8;
    localparam int TIME_W     = 64;
    localparam int KIND_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    // Widest id and fill count over the legal parameter ranges.
    localparam int ID_MAX_W   = 16;
    localparam int FILL_MAX_W = 9;

    localparam logic [KIND_W-1:0] KIND_SPAWN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POLL     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUTCOME_YIELD = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_WAIT  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DONE  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_READY_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_WAIT_FULL  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an accepted input transaction
        logic push_in;     // push the input id onto the ready queue
        logic pop;         // pop the ready queue head
        logic set_empty;   // dispatch found the ready queue empty
        logic park;        // park the input id in the timer table
        logic scan_start;  // begin a tick scan at entry zero
        logic scan_eval;   // evaluate the timer entry just read
        logic grant;       // latch the popped id
        logic out_load;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [OUTCOME_W-1:0] outcome;
        logic                 ready_empty;
        logic                 scan_end;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/task_ready_queue_timer_scheduler_top.sv -----
// ============================================================================
// task_ready_queue_timer_scheduler_top
// Task executor with a circular ready queue and a timer table of task ids.
// ============================================================================
// One transaction in gives one result out. Spawn, poll report and an empty
// dispatch go from acceptance through a decode state to the result register;
// a successful dispatch adds a grant state, as the ready queue memory has a
// registered read. A tick scan alternates a read state and an evaluate state
// for each timer table entry until the index reaches the fill count. One
// transaction is worked on at a time; the next is accepted while the previous
// result still waits in the output register.
`default_nettype none

module task_ready_queue_timer_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] task_id, [9:8] outcome, [73:10] wake_time, [137:74] now, rest zero
    input  wire logic [trq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  wire logic [trq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] granted_id, [8] granted, [10:9] status, [15:11] woken_count,
    // [20:16] ready_count, [25:21] waiting_count, [26] all_idle, rest zero
    output logic [trq_pkg::M_TDATA_W-1:0]      m_tdata
);

    trq_pkg::cmd_t  cmd;
    trq_pkg::stat_t st;

    trq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    trq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .st      (st),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/trq_ctrl.sv -----
// ============================================================================
// trq_ctrl
// Controller state machine: sequences each transaction through decode,
// queue access or timer scan, and the result register handshake.
// ============================================================================
`default_nettype none

module trq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire trq_pkg::stat_t st,
    output trq_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_GRANT   = 3'd2;
    localparam logic [2:0] ST_SCAN_RD = 3'd3;
    localparam logic [2:0] ST_SCAN_EV = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                unique case (st.kind)
                    trq_pkg::KIND_SPAWN: begin
                        cmd.push_in = 1'b1;
                    end
                    trq_pkg::KIND_DISPATCH: begin
                        if (st.ready_empty) begin
                            cmd.set_empty = 1'b1;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = ST_GRANT;
                        end
                    end
                    trq_pkg::KIND_POLL: begin
                        case (st.outcome)
                            trq_pkg::OUTCOME_YIELD: cmd.push_in = 1'b1;
                            trq_pkg::OUTCOME_WAIT:  cmd.park    = 1'b1;
                            default: ;
                        endcase
                    end
                    trq_pkg::KIND_TICK: begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                    default: ;
                endcase
            end
            ST_GRANT: begin
                cmd.grant  = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN_RD: begin
                // The timer table read for the current index is registered here and evaluated in the next state.
                state_next = st.scan_end ? ST_DONE : ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                cmd.scan_eval = 1'b1;
                state_next    = ST_SCAN_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/trq_datapath.sv -----
// ============================================================================
// trq_datapath
// Ready queue memory, timer table memory, pointers, fill counts, scan index
// and the result register.
// ============================================================================
`default_nettype none

module trq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [trq_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [trq_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire trq_pkg::cmd_t                     cmd,
    output trq_pkg::stat_t                         st,
    output logic [trq_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    // Captured input fields.
    logic [trq_pkg::KIND_W-1:0]    kind_reg;
    logic [trq_pkg::TASK_ID_W-1:0] task_id_reg;
    logic [trq_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [trq_pkg::TIME_W-1:0]    wake_reg;
    logic [trq_pkg::TIME_W-1:0]    now_reg;

    // Queue and table control.
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [FW-1:0] rfill_reg, rfill_next;
    logic [FW-1:0] wfill_reg, wfill_next;
    logic [FW-1:0] scan_reg, scan_next;

    // Per-transaction result work registers.
    logic [trq_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          granted_reg, granted_next;
    logic [trq_pkg::TASK_ID_W-1:0] gid_reg, gid_next;
    logic [FW-1:0]                 woken_reg, woken_next;

    // Result register.
    logic [trq_pkg::M_TDATA_W-1:0] out_reg, out_next;

    // Memories.
    logic [ID_BITS-1:0]             ready_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0]             wid_mem   [QUEUE_DEPTH];
    logic [trq_pkg::TIME_W-1:0]     wdue_mem  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]             ready_rd_reg;
    logic [ID_BITS-1:0]             wid_i_reg;
    logic [trq_pkg::TIME_W-1:0]     wdue_i_reg;
    logic [ID_BITS-1:0]             wid_l_reg;
    logic [trq_pkg::TIME_W-1:0]     wdue_l_reg;

    logic                           ready_full;
    logic                           wait_full;
    logic                           due;
    logic                           ready_we;
    logic [ID_BITS-1:0]             ready_wdata;
    logic                           wait_we;
    logic [IW-1:0]                  wait_waddr;
    logic [ID_BITS-1:0]             wait_wid;
    logic [trq_pkg::TIME_W-1:0]     wait_wdue;
    logic [IW-1:0]                  scan_idx;
    logic [FW-1:0]                  wlast;
    logic [ID_BITS-1:0]             id_in;
    logic [trq_pkg::ID_MAX_W-1:0]   id_ext;
    logic [trq_pkg::ID_MAX_W-1:0]   gid_ext;
    logic [trq_pkg::FILL_MAX_W-1:0] rfill_ext;
    logic [trq_pkg::FILL_MAX_W-1:0] wfill_ext;
    logic [trq_pkg::FILL_MAX_W-1:0] woken_ext;

    assign id_ext     = trq_pkg::ID_MAX_W'(task_id_reg);
    assign id_in      = id_ext[ID_BITS-1:0];
    assign gid_ext    = trq_pkg::ID_MAX_W'(ready_rd_reg);
    assign ready_full = (rfill_reg == FW'(QUEUE_DEPTH));
    assign wait_full  = (wfill_reg == FW'(QUEUE_DEPTH));
    assign scan_idx   = scan_reg[IW-1:0];
    assign wlast      = wfill_reg - FW'(1);
    assign due        = (now_reg >= wdue_i_reg);

    assign st.kind        = kind_reg;
    assign st.outcome     = outcome_reg;
    assign st.ready_empty = (rfill_reg == '0);
    assign st.scan_end    = (scan_reg >= wfill_reg);

    // Ready queue write port: input pushes and timer wakeups.
    always_comb begin
        ready_we    = 1'b0;
        ready_wdata = id_in;
        if (cmd.push_in && !ready_full) begin
            ready_we = 1'b1;
        end else if (cmd.scan_eval && due && !ready_full) begin
            ready_we    = 1'b1;
            ready_wdata = wid_i_reg;
        end
    end

    // Timer table write port: parking appends, a wakeup moves the last entry down.
    always_comb begin
        wait_we    = 1'b0;
        wait_waddr = wfill_reg[IW-1:0];
        wait_wid   = id_in;
        wait_wdue  = wake_reg;
        if (cmd.park && !wait_full) begin
            wait_we = 1'b1;
        end else if (cmd.scan_eval && due && !ready_full) begin
            wait_we    = 1'b1;
            wait_waddr = scan_idx;
            wait_wid   = wid_l_reg;
            wait_wdue  = wdue_l_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_we) begin
            ready_mem[tail_reg] <= ready_wdata;
        end
        ready_rd_reg <= ready_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (wait_we) begin
            wid_mem[wait_waddr]  <= wait_wid;
            wdue_mem[wait_waddr] <= wait_wdue;
        end
        wid_i_reg  <= wid_mem[scan_idx];
        wdue_i_reg <= wdue_mem[scan_idx];
        wid_l_reg  <= wid_mem[wlast[IW-1:0]];
        wdue_l_reg <= wdue_mem[wlast[IW-1:0]];
    end

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        rfill_next   = rfill_reg;
        wfill_next   = wfill_reg;
        scan_next    = scan_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        gid_next     = gid_reg;
        woken_next   = woken_reg;

        if (cmd.load) begin
            status_next  = trq_pkg::STATUS_OK;
            granted_next = 1'b0;
            gid_next     = '0;
            woken_next   = '0;
        end

        if (ready_we) begin
            tail_next  = (tail_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + IW'(1);
            rfill_next = rfill_reg + FW'(1);
        end

        if (cmd.push_in && ready_full) begin
            status_next = trq_pkg::STATUS_READY_FULL;
        end

        if (cmd.pop) begin
            head_next  = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IW'(1);
            rfill_next = rfill_reg - FW'(1);
        end

        if (cmd.set_empty) begin
            status_next = trq_pkg::STATUS_EMPTY;
        end

        if (cmd.grant) begin
            granted_next = 1'b1;
            gid_next     = gid_ext[trq_pkg::TASK_ID_W-1:0];
        end

        if (cmd.park) begin
            if (wait_full) begin
                status_next = trq_pkg::STATUS_WAIT_FULL;
            end else begin
                wfill_next = wfill_reg + FW'(1);
            end
        end

        if (cmd.scan_start) begin
            scan_next = '0;
        end

        // A woken entry is replaced by the last one and the same index is
        // examined again; otherwise the scan moves on.
        if (cmd.scan_eval) begin
            if (due && !ready_full) begin
                wfill_next = wlast;
                woken_next = woken_reg + FW'(1);
            end else begin
                scan_next = scan_reg + FW'(1);
                if (due) begin
                    status_next = trq_pkg::STATUS_READY_FULL;
                end
            end
        end
    end

    assign rfill_ext = trq_pkg::FILL_MAX_W'(rfill_reg);
    assign wfill_ext = trq_pkg::FILL_MAX_W'(wfill_reg);
    assign woken_ext = trq_pkg::FILL_MAX_W'(woken_reg);

    always_comb begin
        out_next = out_reg;
        if (cmd.out_load) begin
            out_next = {5'b0,
                        (rfill_reg == '0) && (wfill_reg == '0),
                        wfill_ext[trq_pkg::COUNT_W-1:0],
                        rfill_ext[trq_pkg::COUNT_W-1:0],
                        woken_ext[trq_pkg::COUNT_W-1:0],
                        status_reg,
                        granted_reg,
                        gid_reg};
        end
    end

    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_tuser;
            task_id_reg <= s_tdata[7:0];
            outcome_reg <= s_tdata[9:8];
            wake_reg    <= s_tdata[73:10];
            now_reg     <= s_tdata[137:74];
        end
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        gid_reg     <= gid_next;
        woken_reg   <= woken_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            rfill_reg <= '0;
            wfill_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            rfill_reg <= rfill_next;
            wfill_reg <= wfill_next;
        end
    end

endmodule

`default_nettype wire
